// ===== design/sfi_pkg.sv =====
// ----------------------------------------------------------------------------
// sfi_pkg: shared types and constants for the substring first-index search
// Target and window sizes, position counter width and the command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sfi_pkg;

   // Target capacity and the source length at which the position saturates
   localparam int unsigned MAX_TARGET = 16;
   localparam longint unsigned MAX_SOURCE = 64'd65535;

   localparam int POS_W = 16;
   localparam int LEN_W = $clog2(MAX_TARGET + 1);
   localparam int IDX_W = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;

   localparam logic [POS_W-1:0] POS_CAP =
      (MAX_SOURCE < 64'd65535) ? POS_W'(MAX_SOURCE) : POS_W'(65535);

   typedef logic [7:0]       byte_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [LEN_W-1:0] len_type;
   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic {
      CMD_TARGET = 1'b0,
      CMD_SOURCE = 1'b1
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/sfi_if.sv =====
// ----------------------------------------------------------------------------
// sfi_if: request and response channels of the substring search
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfi_req_if
   import sfi_pkg::*;
   ;
   logic     valid;
   logic     ready;
   logic     cmd;
   byte_type data_byte;
   logic     last;

   modport source (output valid, output cmd, output data_byte, output last, input ready);
   modport sink   (input valid, input cmd, input data_byte, input last, output ready);
endinterface

interface sfi_rsp_if
   import sfi_pkg::*;
   ;
   logic    valid;
   logic    ready;
   pos_type found_position;
   logic    overflow;

   modport source (output valid, output found_position, output overflow, input ready);
   modport sink   (input valid, input found_position, input overflow, output ready);
endinterface

`default_nettype wire

// ===== design/substring_first_index.sv =====
// ----------------------------------------------------------------------------
// substring_first_index: first position of a target string in a byte stream
// Loads a target of up to MAX_TARGET bytes, then compares the whole target
// against a shift window of the source on every source byte.
// ----------------------------------------------------------------------------
//
//  channel   direction  beat contents                     beats
//  req_bus   in         cmd, data_byte, last              target or source byte
//  rsp_bus   out        found_position, overflow          one per source string
//
//  One beat is taken every cycle unless a held response stalls the input
//  register. A beat lands in the input register, then one pass of window
//  shift, parallel compare and counter update retires it; the last source
//  byte loads the result register, from which the result is valid.
//  Synchronous reset clears the target length, the search state and both
//  valid flags; target and window bytes are left as they are.
//  A held response stalls the input register only when the beat in it would
//  produce a further result; other beats keep flowing.
//
`default_nettype none

module substring_first_index
   import sfi_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   sfi_req_if.sink    req_bus,
   sfi_rsp_if.source  rsp_bus
);

   // Input register
   logic     s1_valid_ff, s1_valid_in;
   logic     s1_cmd_ff;
   byte_type s1_byte_ff;
   logic     s1_last_ff;

   // Target store and search state
   byte_type target_ff [MAX_TARGET];
   len_type  target_len_ff, target_len_in;
   logic     target_open_ff, target_open_in;
   byte_type window_ff [MAX_TARGET];
   pos_type  source_count_ff, source_count_in;
   pos_type  match_start_ff, match_start_in;
   logic     count_ovf_ff, count_ovf_in;

   // Result register
   logic     rsp_valid_ff, rsp_valid_in;
   pos_type  rsp_pos_ff, rsp_pos_in;
   logic     rsp_ovf_ff, rsp_ovf_in;

   logic     s1_makes_rsp;
   logic     s1_advance;
   logic     req_take;
   logic     do_target;
   logic     do_source;
   len_type  load_len;
   byte_type win_new [MAX_TARGET];
   logic     window_hit;
   logic     count_sat;

   // Advance the input register unless its beat needs a result slot that is full
   assign s1_makes_rsp = (s1_cmd_ff == CMD_SOURCE) && s1_last_ff;
   assign s1_advance   = s1_valid_ff && (!s1_makes_rsp || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign req_take     = req_bus.valid && req_bus.ready;

   assign do_target = s1_advance && (s1_cmd_ff == CMD_TARGET);
   assign do_source = s1_advance && (s1_cmd_ff == CMD_SOURCE);

   // A target byte after a closed target restarts the load
   assign load_len = target_open_ff ? target_len_ff : '0;

   // Window after shifting in the current byte; [0] is the newest
   always_comb begin
      win_new[0] = s1_byte_ff;
      for (int k = 1; k < MAX_TARGET; k++) begin
         win_new[k] = window_ff[k-1];
      end
   end

   // Parallel compare: target byte k against window tap len-1-k
   always_comb begin
      idx_type tap;
      window_hit = (target_len_ff != '0);
      tap = '0;
      for (int k = 0; k < MAX_TARGET; k++) begin
         tap = IDX_W'(int'(target_len_ff) - 1 - k);
         if ((int'(target_len_ff) > k) && (target_ff[k] != win_new[tap])) begin
            window_hit = 1'b0;
         end
      end
   end

   assign count_sat = (source_count_ff == POS_CAP);

   // Next state of the search
   always_comb begin
      s1_valid_in     = s1_valid_ff;
      target_len_in   = target_len_ff;
      target_open_in  = target_open_ff;
      source_count_in = source_count_ff;
      match_start_in  = match_start_ff;
      count_ovf_in    = count_ovf_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_pos_in      = rsp_pos_ff;
      rsp_ovf_in      = rsp_ovf_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      if (do_target) begin
         target_open_in = !s1_last_ff;
         target_len_in  = (load_len < LEN_W'(MAX_TARGET)) ? load_len + 1'b1 : load_len;
         source_count_in = '0;
         match_start_in  = '0;
         count_ovf_in    = 1'b0;
      end

      if (do_source) begin
         if (count_sat) begin
            count_ovf_in = 1'b1;
         end else begin
            source_count_in = source_count_ff + 1'b1;
         end
         if (!count_ovf_in && (match_start_ff == '0) && window_hit
             && (source_count_in >= POS_W'(target_len_ff))) begin
            match_start_in = source_count_in - POS_W'(target_len_ff) + 1'b1;
         end
         // Capture the result before the clear that the last byte applies
         if (s1_last_ff) begin
            rsp_valid_in    = 1'b1;
            rsp_pos_in      = match_start_in;
            rsp_ovf_in      = count_ovf_in;
            source_count_in = '0;
            match_start_in  = '0;
            count_ovf_in    = 1'b0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         target_len_ff   <= '0;
         target_open_ff  <= 1'b0;
         source_count_ff <= '0;
         match_start_ff  <= '0;
         count_ovf_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         target_len_ff   <= target_len_in;
         target_open_ff  <= target_open_in;
         source_count_ff <= source_count_in;
         match_start_ff  <= match_start_in;
         count_ovf_ff    <= count_ovf_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers: input beat, target bytes, window, result
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff  <= req_bus.cmd;
         s1_byte_ff <= req_bus.data_byte;
         s1_last_ff <= req_bus.last;
      end
      if (do_target && (load_len < LEN_W'(MAX_TARGET))) begin
         target_ff[IDX_W'(load_len)] <= s1_byte_ff;
      end
      if (do_source) begin
         for (int k = 0; k < MAX_TARGET; k++) begin
            window_ff[k] <= win_new[k];
         end
      end
      if (do_source && s1_last_ff) begin
         rsp_pos_ff <= rsp_pos_in;
         rsp_ovf_ff <= rsp_ovf_in;
      end
   end

   // Drive the response channel straight from the result register
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.found_position = rsp_pos_ff;
   assign rsp_bus.overflow       = rsp_ovf_ff;

   // Overflow only once the counter sits at its cap
   a_ovf_at_cap: assert property (@(posedge clock) disable iff (reset)
      count_ovf_ff |-> (source_count_ff == POS_CAP))
      else $error("overflow flagged below the position cap");

   // A recorded start never lies beyond the bytes counted so far
   a_start_in_range: assert property (@(posedge clock) disable iff (reset)
      (match_start_ff != '0) |-> (match_start_ff <= source_count_ff))
      else $error("match start beyond source count");

   // Target length stays within the store
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      target_len_ff <= LEN_W'(MAX_TARGET))
      else $error("target length beyond capacity");

   // The last source byte raises a result and clears the search
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (do_source && s1_last_ff) |=> (rsp_valid_ff && (source_count_ff == '0)
                                     && (match_start_ff == '0) && !count_ovf_ff))
      else $error("search not cleared after last source byte");

   // A beat that needs the result slot is never retired into a held result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !(do_source && s1_last_ff))
      else $error("result overwritten while held");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for substring_first_index
// Walks a table of directed beats (empty target, extremes, open and
// oversized targets, counter saturation), then random target/source
// sessions, all scored against an in-bench model of the search.
// ----------------------------------------------------------------------------

module tb;
   import sfi_pkg::*;

   // One row of the directed table: the beat is sent reps times, last only
   // on the final copy; typed rows carry the result read straight off the spec
   typedef struct packed {
      cmd_type  cmd;
      byte_type data;
      logic     last;
      int       reps;
      logic     typed;
      pos_type  pos;
      logic     ovf;
   } row_rec;

   typedef struct packed {
      cmd_type  cmd;
      byte_type data;
      logic     last;
      logic     typed;
      pos_type  pos;
      logic     ovf;
   } beat_rec;

   typedef struct packed {
      pos_type pos;
      logic    ovf;
   } hit_rec;

   localparam int N_ROWS = 27;

   // Directed table.  Long rows push the position counter to and past its cap.
   localparam row_rec SEARCH_ROWS [N_ROWS] = '{
      // empty target after reset: nothing can match
      '{CMD_SOURCE, 8'h00, 1'b1, 1,     1'b1, 16'd0,     1'b0},
      // target FF 00, found inside 00 FF 00
      '{CMD_TARGET, 8'hFF, 1'b0, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_TARGET, 8'h00, 1'b1, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'h00, 1'b0, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'hFF, 1'b0, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'h00, 1'b1, 1,     1'b1, 16'd2,     1'b0},
      // source shorter than the target
      '{CMD_SOURCE, 8'hFF, 1'b1, 1,     1'b1, 16'd0,     1'b0},
      // target byte mid-search drops the search and opens a new target
      '{CMD_SOURCE, 8'hFF, 1'b0, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_TARGET, 8'h5A, 1'b0, 1,     1'b0, 16'd0,     1'b0},
      // search against the target loaded so far
      '{CMD_SOURCE, 8'h5A, 1'b1, 1,     1'b1, 16'd1,     1'b0},
      // still open: this byte appends
      '{CMD_TARGET, 8'hA5, 1'b1, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'h5A, 1'b0, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'hA5, 1'b1, 1,     1'b1, 16'd1,     1'b0},
      // oversized target: only the first sixteen bytes are kept
      '{CMD_TARGET, 8'h33, 1'b1, 17,    1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'h33, 1'b1, 15,    1'b1, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'h33, 1'b1, 16,    1'b1, 16'd1,     1'b0},
      // early match survives saturation of the counter
      '{CMD_TARGET, 8'h41, 1'b0, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_TARGET, 8'h42, 1'b1, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'h41, 1'b0, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'h42, 1'b0, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'h00, 1'b1, 65534, 1'b1, 16'd1,     1'b1},
      // match ending past saturation is not recorded
      '{CMD_SOURCE, 8'h00, 1'b0, 65535, 1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'h41, 1'b0, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'h42, 1'b1, 1,     1'b1, 16'd0,     1'b1},
      // match on the very last countable byte: top position, no overflow
      '{CMD_TARGET, 8'hC3, 1'b1, 1,     1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'h00, 1'b0, 65534, 1'b0, 16'd0,     1'b0},
      '{CMD_SOURCE, 8'hC3, 1'b1, 1,     1'b1, 16'hFFFF,  1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   sfi_req_if req_bus ();
   sfi_rsp_if rsp_bus ();

   substring_first_index u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Search model: target store, source window and position counter
   // ------------------------------------------------------------------------
   byte_type tgt_mem [MAX_TARGET];
   len_type  tgt_len  = '0;
   bit       tgt_open = 1'b0;
   byte_type win_mem [MAX_TARGET] = '{default: 8'h00};
   pos_type  src_count = '0;
   pos_type  first_hit = '0;
   bit       sat_flag  = 1'b0;

   beat_rec  beat_q [$];    // beats waiting to be offered
   hit_rec   hit_q  [$];    // positions still owed by the block
   int       beats_pushed = 0;
   int       beats_done   = 0;
   int       fail_count   = 0;
   int       results_seen = 0;
   int       hits_seen    = 0;
   int       sat_seen     = 0;
   int       tx_idle_pct  = 17;
   int       rx_idle_pct  = 17;
   bit       hold_req     = 1'b0;

   function automatic void drop_search();
      foreach (win_mem[i]) win_mem[i] = 8'h00;
      src_count = '0;
      first_hit = '0;
      sat_flag  = 1'b0;
   endfunction

   // Advance the model by one accepted beat; return 1 when it closes a source
   function automatic bit search_beat(cmd_type c, byte_type b, logic lst,
                                      output hit_rec r);
      bit hit;
      r = '0;
      if (c == CMD_TARGET) begin
         if (!tgt_open) begin
            tgt_len  = '0;
            tgt_open = 1'b1;
         end
         if (tgt_len < MAX_TARGET) begin
            tgt_mem[tgt_len] = b;
            tgt_len = tgt_len + 1'b1;
         end
         if (lst) tgt_open = 1'b0;
         drop_search();
         return 1'b0;
      end
      for (int k = MAX_TARGET - 1; k > 0; k--) win_mem[k] = win_mem[k-1];
      win_mem[0] = b;
      if (src_count >= POS_CAP) sat_flag = 1'b1;
      else src_count = src_count + 1'b1;
      // oldest window byte lines up with the first target byte
      hit = (tgt_len != 0) && (src_count >= tgt_len);
      for (int k = 0; k < MAX_TARGET; k++)
         if (k < tgt_len && tgt_mem[k] != win_mem[tgt_len - 1 - k]) hit = 1'b0;
      if (!sat_flag && first_hit == 0 && hit)
         first_hit = src_count - tgt_len + 1'b1;
      if (!lst) return 1'b0;
      r.pos = first_hit;
      r.ovf = sat_flag;
      drop_search();
      return 1'b1;
   endfunction

   task automatic queue_beat(cmd_type c, byte_type b, logic lst);
      beat_q.push_back('{c, b, lst, 1'b0, 16'd0, 1'b0});
      beats_pushed++;
   endtask

   // One random session: load a target, run a few sources over it.
   // Most sources carry a copy of the target drawn from a narrow alphabet.
   task automatic queue_session(output int n);
      byte_type pat   [$];
      byte_type src   [$];
      byte_type alpha [4];
      int       tlen, eff, slen, at;
      bit       narrow, keep_open;
      n = 0;
      // occasional noise ahead of the session
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(3, 1)) begin
            queue_beat(cmd_type'($urandom_range(1)), byte_type'($urandom),
                       logic'($urandom_range(1)));
            n++;
         end
      narrow = $urandom_range(1);
      foreach (alpha[i]) alpha[i] = byte_type'($urandom);
      tlen = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
      eff  = (tlen > MAX_TARGET) ? MAX_TARGET : tlen;
      keep_open = ($urandom_range(6) == 0);
      for (int k = 0; k < tlen; k++) begin
         pat.push_back(narrow ? alpha[$urandom_range(1)] : byte_type'($urandom));
         queue_beat(CMD_TARGET, pat[k], !keep_open && k == tlen - 1);
         n++;
      end
      repeat ($urandom_range(4, 1)) begin
         slen = $urandom_range(tlen * 2 + 6, 1);
         src = {};
         for (int j = 0; j < slen; j++)
            src.push_back(alpha[$urandom_range(narrow ? 1 : 3)]);
         if ($urandom_range(9) < 6 && slen >= eff) begin
            at = $urandom_range(slen - eff);
            for (int j = 0; j < eff; j++) src[at + j] = pat[j];
         end
         for (int j = 0; j < slen; j++) begin
            // break the search now and then with a stray target byte
            if (j > 0 && $urandom_range(39) == 0) begin
               queue_beat(CMD_TARGET, byte_type'($urandom), $urandom_range(3) != 0);
               n++;
            end
            queue_beat(CMD_SOURCE, src[j], j == slen - 1);
            n++;
         end
      end
      if (keep_open) begin
         queue_beat(CMD_TARGET, byte_type'($urandom), 1'b1);
         n++;
      end
   endtask

   task automatic queue_random(int want);
      int got, n;
      got = 0;
      while (got < want) begin
         queue_session(n);
         got += n;
      end
   endtask

   // Hold until every queued beat is taken and every result has come back
   task automatic drain();
      while (beats_done != beats_pushed || hit_q.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Sender: offer beats, score them against the model as they are taken
   // ------------------------------------------------------------------------
   initial begin : sender
      beat_rec cur;
      hit_rec  hit;
      bit      loaded;
      bit      taken;
      loaded            = 1'b0;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_TARGET;
      req_bus.data_byte = 8'h00;
      req_bus.last      = 1'b0;
      forever begin
         @(posedge clock);
         taken = !reset && req_bus.valid && req_bus.ready;
         if (taken) begin
            if (search_beat(cur.cmd, cur.data, cur.last, hit))
               hit_q.push_back(cur.typed ? hit_rec'{pos: cur.pos, ovf: cur.ovf} : hit);
            beats_done++;
            loaded = 1'b0;
         end
         if (!loaded && beat_q.size() != 0) begin
            cur    = beat_q.pop_front();
            loaded = 1'b1;
         end
         // a beat on offer stays put until it is taken
         if (!(req_bus.valid && !taken)) begin
            if (loaded && !reset && $urandom_range(99) >= tx_idle_pct) begin
               req_bus.valid     <= 1'b1;
               req_bus.cmd       <= cur.cmd;
               req_bus.data_byte <= cur.data;
               req_bus.last      <= cur.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall at random, check each result against the oldest owed
   // ------------------------------------------------------------------------
   initial begin : receiver
      hit_rec want;
      int     hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (rsp_bus.found_position != 0) hits_seen++;
            if (rsp_bus.overflow) sat_seen++;
            if (hit_q.size() == 0) begin
               $error("unexpected result beat: found_position %0d overflow %0d",
                      rsp_bus.found_position, rsp_bus.overflow);
               fail_count++;
            end else begin
               want = hit_q.pop_front();
               if (rsp_bus.found_position !== want.pos) begin
                  $error("found_position: expected %0d, got %0d",
                         want.pos, rsp_bus.found_position);
                  fail_count++;
               end
               if (rsp_bus.overflow !== want.ovf) begin
                  $error("overflow: expected %0d, got %0d", want.ovf, rsp_bus.overflow);
                  fail_count++;
               end
            end
         end
         if (hold_req) begin
            hold_left = 400;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table, expanded row by row
      foreach (SEARCH_ROWS[r])
         for (int i = 0; i < SEARCH_ROWS[r].reps; i++) begin
            beat_q.push_back('{SEARCH_ROWS[r].cmd, SEARCH_ROWS[r].data,
                               (i == SEARCH_ROWS[r].reps - 1) ? SEARCH_ROWS[r].last : 1'b0,
                               (i == SEARCH_ROWS[r].reps - 1) ? SEARCH_ROWS[r].typed : 1'b0,
                               SEARCH_ROWS[r].pos, SEARCH_ROWS[r].ovf});
            beats_pushed++;
         end
      drain();

      // random sessions with idling on both sides
      queue_random(600);
      drain();

      // back-to-back stretch with no idling at all
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      queue_random(500);
      drain();

      // long receiver hold-off while beats keep coming, to stall the input
      tx_idle_pct = 17;
      rx_idle_pct = 17;
      hold_req    = 1'b1;
      queue_random(600);
      drain();

      // allow for the pipeline before the last look
      repeat (8) @(posedge clock);
      if (hit_q.size() != 0) begin
         $error("%0d results never arrived", hit_q.size());
         fail_count++;
      end

      $display("Sent %0d beats (directed table plus random target/source sessions).",
               beats_done);
      $display("Checked %0d results: %0d with a match, %0d with counter overflow.",
               results_seen, hits_seen, sat_seen);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin : watchdog
      #40_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
design/sfi_pkg.sv
design/sfi_if.sv
design/substring_first_index.sv
tb/tb.sv
